// ===== src/pit_pkg.sv =====
// Shared definitions for the point-in-tetrahedron test pipeline.
// Used by pit_face and point_in_tetrahedron_test; depends on nothing.
package pit_pkg;

  // Default coordinate width of one signed lane.
  localparam int unsigned PIT_COORD_BITS = 16;

  // Per-stage load enables of the compute pipeline, stage 1 first.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } pit_adv_t;

endpackage

// ===== src/pit_face.sv =====
// One face of the same-side test as a five-stage pipeline: edge differences,
// cross products, normal, dot products, sign compare. Depends on pit_pkg.
module pit_face import pit_pkg::*; #(
  parameter int unsigned COORD_BITS = PIT_COORD_BITS
) (
  input  logic                    clk,
  input  pit_adv_t                adv,
  input  logic [3*COORD_BITS-1:0] v1,
  input  logic [3*COORD_BITS-1:0] v2,
  input  logic [3*COORD_BITS-1:0] v3,
  input  logic [3*COORD_BITS-1:0] opp,
  input  logic [3*COORD_BITS-1:0] q,
  output logic                    face_ok
);

  localparam int unsigned DW = COORD_BITS + 1;   // coordinate difference
  localparam int unsigned PW = 2 * DW;           // cross-product term
  localparam int unsigned NW = PW + 1;           // normal component
  localparam int unsigned QW = NW + DW;          // dot-product term
  localparam int unsigned SW = QW + 2;           // dot-product sum

  logic signed [DW-1:0] e1_r  [3];
  logic signed [DW-1:0] e2_r  [3];
  logic signed [DW-1:0] do1_r [3];
  logic signed [DW-1:0] dq1_r [3];
  logic signed [DW-1:0] do2_r [3];
  logic signed [DW-1:0] dq2_r [3];
  logic signed [DW-1:0] do3_r [3];
  logic signed [DW-1:0] dq3_r [3];
  logic signed [PW-1:0] pa_r  [3];
  logic signed [PW-1:0] pb_r  [3];
  logic signed [NW-1:0] n_r   [3];
  logic signed [QW-1:0] mo_r  [3];
  logic signed [QW-1:0] mq_r  [3];
  logic                 ok_r;

  logic signed [SW-1:0] sum_o_nxt;
  logic signed [SW-1:0] sum_q_nxt;
  logic                 ok_nxt;

  for (genvar k = 0; k < 3; k++) begin : g_axis
    localparam int K1 = (k + 1) % 3;
    localparam int K2 = (k + 2) % 3;

    logic signed [COORD_BITS-1:0] c1, c2, c3, co, cq;
    logic signed [DW-1:0] e1_nxt, e2_nxt, do_nxt, dq_nxt;
    logic signed [PW-1:0] pa_nxt, pb_nxt;
    logic signed [NW-1:0] n_nxt;
    logic signed [QW-1:0] mo_nxt, mq_nxt;

    assign c1 = v1[k*COORD_BITS +: COORD_BITS];
    assign c2 = v2[k*COORD_BITS +: COORD_BITS];
    assign c3 = v3[k*COORD_BITS +: COORD_BITS];
    assign co = opp[k*COORD_BITS +: COORD_BITS];
    assign cq = q[k*COORD_BITS +: COORD_BITS];

    assign e1_nxt = DW'(c2) - DW'(c1);
    assign e2_nxt = DW'(c3) - DW'(c1);
    assign do_nxt = DW'(co) - DW'(c1);
    assign dq_nxt = DW'(cq) - DW'(c1);

    // Normal component k = e1[k+1]*e2[k+2] - e1[k+2]*e2[k+1].
    assign pa_nxt = PW'(e1_r[K1]) * PW'(e2_r[K2]);
    assign pb_nxt = PW'(e1_r[K2]) * PW'(e2_r[K1]);
    assign n_nxt  = NW'(pa_r[k]) - NW'(pb_r[k]);
    assign mo_nxt = QW'(n_r[k]) * QW'(do3_r[k]);
    assign mq_nxt = QW'(n_r[k]) * QW'(dq3_r[k]);

    always_ff @(posedge clk) begin
      if (adv.s1) begin
        e1_r[k]  <= e1_nxt;
        e2_r[k]  <= e2_nxt;
        do1_r[k] <= do_nxt;
        dq1_r[k] <= dq_nxt;
      end
      if (adv.s2) begin
        pa_r[k]  <= pa_nxt;
        pb_r[k]  <= pb_nxt;
        do2_r[k] <= do1_r[k];
        dq2_r[k] <= dq1_r[k];
      end
      if (adv.s3) begin
        n_r[k]   <= n_nxt;
        do3_r[k] <= do2_r[k];
        dq3_r[k] <= dq2_r[k];
      end
      if (adv.s4) begin
        mo_r[k]  <= mo_nxt;
        mq_r[k]  <= mq_nxt;
      end
    end
  end

  // A zero sum counts as non-negative, so only the sign bits are compared.
  assign sum_o_nxt = SW'(mo_r[0]) + SW'(mo_r[1]) + SW'(mo_r[2]);
  assign sum_q_nxt = SW'(mq_r[0]) + SW'(mq_r[1]) + SW'(mq_r[2]);
  assign ok_nxt    = (sum_o_nxt[SW-1] == sum_q_nxt[SW-1]);

  always_ff @(posedge clk) begin
    if (adv.s5) begin
      ok_r <= ok_nxt;
    end
  end

  assign face_ok = ok_r;

endmodule

// ===== src/point_in_tetrahedron_test.sv =====
// Top level of the point-in-tetrahedron same-side test pipeline.
// Instantiates four pit_face units; depends on pit_pkg.
//
//   Channel  Ports                                   Direction  Handshake
//   input    in_query_point, in_corner_a..d          in         in_valid / in_ready
//   result   out_is_inside                           out        out_valid / out_ready
//
// One item is taken every cycle while in_ready is high. An accepted item
// passes the five compute stages in pit_face (the first loads at the
// transfer edge) and then the output register here before out_valid rises.
// The multipliers of the dot-product stage set the depth of the slowest stage.
// Reset clears only the valid bits. When out_ready is low, stages with empty
// slots keep loading, so bubbles collapse and in_ready falls only once every
// stage and the output register hold an item.
module point_in_tetrahedron_test import pit_pkg::*; #(
  parameter int unsigned COORD_BITS = PIT_COORD_BITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [3*COORD_BITS-1:0] in_query_point,
  input  logic [3*COORD_BITS-1:0] in_corner_a,
  input  logic [3*COORD_BITS-1:0] in_corner_b,
  input  logic [3*COORD_BITS-1:0] in_corner_c,
  input  logic [3*COORD_BITS-1:0] in_corner_d,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_is_inside
);

  localparam int unsigned NUM_STAGES = 5;

  // Valid bit of each compute stage; bit 0 is stage 1.
  logic [NUM_STAGES-1:0]   vld_r;
  logic [NUM_STAGES-1:0]   vld_nxt;
  logic                    out_valid_r;
  logic                    out_valid_nxt;
  logic                    out_is_inside_r;
  logic                    adv_out;
  pit_adv_t                adv;
  logic [3*COORD_BITS-1:0] corner [4];
  logic [3:0]              face_ok;

  // A stage loads when it is empty or when the stage after it loads too.
  assign adv_out = !out_valid_r || out_ready;
  assign adv.s5  = !vld_r[4] || adv_out;
  assign adv.s4  = !vld_r[3] || adv.s5;
  assign adv.s3  = !vld_r[2] || adv.s4;
  assign adv.s2  = !vld_r[1] || adv.s3;
  assign adv.s1  = !vld_r[0] || adv.s2;
  assign in_ready = adv.s1;

  assign corner[0] = in_corner_a;
  assign corner[1] = in_corner_b;
  assign corner[2] = in_corner_c;
  assign corner[3] = in_corner_d;

  // Faces (a,b,c | d), (b,c,d | a), (c,d,a | b), (d,a,b | c).
  for (genvar f = 0; f < 4; f++) begin : g_face
    pit_face #(
      .COORD_BITS(COORD_BITS)
    ) u_face (
      .clk     (clk),
      .adv     (adv),
      .v1      (corner[f]),
      .v2      (corner[(f + 1) % 4]),
      .v3      (corner[(f + 2) % 4]),
      .opp     (corner[(f + 3) % 4]),
      .q       (in_query_point),
      .face_ok (face_ok[f])
    );
  end

  // Valid bits move with the data under the same per-stage enables.
  always_comb begin
    vld_nxt = vld_r;
    if (adv.s1) vld_nxt[0] = in_valid;
    if (adv.s2) vld_nxt[1] = vld_r[0];
    if (adv.s3) vld_nxt[2] = vld_r[1];
    if (adv.s4) vld_nxt[3] = vld_r[2];
    if (adv.s5) vld_nxt[4] = vld_r[3];
    out_valid_nxt = adv_out ? vld_r[4] : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // The point is inside only when it passes all four faces.
  always_ff @(posedge clk) begin
    if (adv_out) begin
      out_is_inside_r <= &face_ok;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_is_inside = out_is_inside_r;

  // The input stalls only when the whole pipeline is full.
  a_full_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (&vld_r) && out_valid_r)
    else $error("in_ready low while a stage is empty");

  // An accepted item occupies stage 1 in the next cycle.
  a_enter_stage1: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> vld_r[0])
    else $error("accepted item did not enter stage 1");

  // A finished item in the last stage reaches the output when it may move.
  a_reach_output: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[4] && adv_out |=> out_valid_r)
    else $error("last stage item lost on its way to the output");

  // Without a new item behind it, a taken result leaves the output.
  a_drain_output: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ready && !vld_r[4] |=> !out_valid_r)
    else $error("result repeated on the output");

endmodule
